[rtl/core/dtd_pkg.sv]
// Package for the date-time difference block: word layouts and calendar tables.
// No dependencies; every other file of the block imports it.

package dtd_pkg;

    // Widths of the fields of a date-time and of the result.
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int DAYS_W    = 22;

    // Calendar limits.
    localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

    // Reciprocal of 100 as a 19-bit fraction; exact for dividends below 43699.
    localparam int RECIP100_W     = 13;
    localparam int RECIP100_SHIFT = 19;
    localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
    localparam int QUOT_W = 9;

    // Month codes used by the range check and the leap-day adjustment.
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Input word: two date-times.
    typedef struct packed {
        logic [DAY_W-1:0]    first_day;
        logic [MONTH_W-1:0]  first_month;
        logic [YEAR_W-1:0]   first_year;
        logic [HOUR_W-1:0]   first_hour;
        logic [MINUTE_W-1:0] first_minute;
        logic [SECOND_W-1:0] first_second;
        logic [DAY_W-1:0]    second_day;
        logic [MONTH_W-1:0]  second_month;
        logic [YEAR_W-1:0]   second_year;
        logic [HOUR_W-1:0]   second_hour;
        logic [MINUTE_W-1:0] second_minute;
        logic [SECOND_W-1:0] second_second;
    } dtd_pair_t;

    // Output word: the absolute difference.
    typedef struct packed {
        logic                invalid;
        logic [DAYS_W-1:0]   day_span;
        logic [HOUR_W-1:0]   hour_span;
        logic [MINUTE_W-1:0] minute_span;
        logic [SECOND_W-1:0] second_span;
    } dtd_span_t;

    // One date-time as handed to the day-count converter.
    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } dtd_stamp_t;

    // Converter result: validity, day number since year 0 and time of day.
    typedef struct packed {
        logic                ok;
        logic [DAYS_W-1:0]   days;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } dtd_days_t;

    // Days in the year before the first of the given month (common year).
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of the given month, February taking the leap flag into account.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
        logic [DAY_W-1:0] n;
        case (month)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/dtd_stamp_if.sv]
// Input channel of the date-time difference block: valid, ready and a pair word.
// Depends on dtd_pkg for the word layout.

interface dtd_stamp_if;
    import dtd_pkg::*;

    logic      valid;
    logic      ready;
    dtd_pair_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/dtd_span_if.sv]
// Output channel of the date-time difference block: valid, ready and a span word.
// Depends on dtd_pkg for the word layout.

interface dtd_span_if;
    import dtd_pkg::*;

    logic      valid;
    logic      ready;
    dtd_span_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/dtd_to_days.sv]
// Two-stage converter from one date-time to a validity flag and a day number.
// Depends on dtd_pkg for types, limits and calendar tables.

module dtd_to_days
    import dtd_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  dtd_stamp_t stamp,
    output dtd_days_t  result
);

    // Stage A registers.
    logic [YEAR_W-1:0]   year_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;
    logic                range_ok_reg;
    logic [DAYS_W-1:0]   y365_reg;
    logic [YEAR_W-2:0]   q4_reg;
    logic [QUOT_W-1:0]   q100_reg;
    logic [QUOT_W-1:0]   q400_reg;
    logic [QUOT_W-1:0]   qy_reg;

    // Stage A next values.
    logic                range_ok_next;
    logic [DAYS_W-1:0]   y365_next;
    logic [YEAR_W:0]     y3;
    logic [YEAR_W:0]     y99;
    logic [YEAR_W:0]     y399;
    logic [YEAR_W-2:0]   y399_div4;
    logic [YEAR_W+RECIP100_W:0] prod100;
    logic [YEAR_W+RECIP100_W:0] prod400;
    logic [YEAR_W+RECIP100_W:0] prody;

    // Stage B values.
    logic [YEAR_W-1:0]   rem100;
    logic                leap;
    logic [DAY_W-1:0]    len;
    logic [DAYS_W-1:0]   dom;
    logic [DAYS_W-1:0]   days_next;
    logic                ok_next;

    // Range checks, year times 365 and the leap-day counts as reciprocal products.
    always_comb
    begin
        range_ok_next = (stamp.month >= MONTH_JAN) && (stamp.month <= MONTH_DEC)
                     && (stamp.year <= YEAR_MAX) && (stamp.hour <= HOUR_MAX)
                     && (stamp.minute <= MINUTE_MAX) && (stamp.second <= SECOND_MAX);
        y365_next = DAYS_W'(stamp.year) * DAYS_W'(365);
        y3        = {1'b0, stamp.year} + (YEAR_W+1)'(3);
        y99       = {1'b0, stamp.year} + (YEAR_W+1)'(99);
        y399      = {1'b0, stamp.year} + (YEAR_W+1)'(399);
        y399_div4 = y399[YEAR_W:2];
        prod100   = (YEAR_W+RECIP100_W+1)'(y99) * (YEAR_W+RECIP100_W+1)'(RECIP100);
        prod400   = (YEAR_W+RECIP100_W+1)'(y399_div4) * (YEAR_W+RECIP100_W+1)'(RECIP100);
        prody     = (YEAR_W+RECIP100_W+1)'(stamp.year) * (YEAR_W+RECIP100_W+1)'(RECIP100);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year_reg     <= stamp.year;
            day_reg      <= stamp.day;
            month_reg    <= stamp.month;
            hour_reg     <= stamp.hour;
            minute_reg   <= stamp.minute;
            second_reg   <= stamp.second;
            range_ok_reg <= range_ok_next;
            y365_reg     <= y365_next;
            q4_reg       <= y3[YEAR_W:2];
            q100_reg     <= prod100[RECIP100_SHIFT+QUOT_W-1:RECIP100_SHIFT];
            q400_reg     <= prod400[RECIP100_SHIFT+QUOT_W-1:RECIP100_SHIFT];
            qy_reg       <= prody[RECIP100_SHIFT+QUOT_W-1:RECIP100_SHIFT];
        end
    end

    // Leap rule, day-of-month check and the day number since year 0.
    always_comb
    begin
        rem100 = year_reg - YEAR_W'(qy_reg) * YEAR_W'(100);
        leap   = (year_reg[1:0] == 2'b00) && ((rem100 != '0) || (qy_reg[1:0] == 2'b00));
        len    = month_len(month_reg, leap);
        ok_next = range_ok_reg && (day_reg != '0) && (day_reg <= len);
        dom    = DAYS_W'(days_before(month_reg)) + DAYS_W'(day_reg) - DAYS_W'(1)
               + DAYS_W'((month_reg > MONTH_FEB) && leap);
        days_next = y365_reg + DAYS_W'(q4_reg) - DAYS_W'(q100_reg)
                  + DAYS_W'(q400_reg) + dom;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result.ok     <= ok_next;
            result.days   <= days_next;
            result.hour   <= hour_reg;
            result.minute <= minute_reg;
            result.second <= second_reg;
        end
    end

endmodule

[rtl/core/datetime_difference.sv]
// Top level of the date-time difference block: validation, ordering and subtraction.
// Depends on dtd_pkg, dtd_stamp_if, dtd_span_if and dtd_to_days.

// A word holds two Gregorian date-times (years 0 to 9999, proleptic calendar).
// The block checks both and returns their absolute difference as days, hours,
// minutes and seconds, or the invalid flag with all spans zero when either
// date-time is malformed. It takes one word per clock cycle while the pipeline
// is not held. A word passes through four register stages: two in each
// day-number converter, one for the compare and swap, and the output register
// after the mixed-radix subtraction. When the output is not taken the whole
// pipeline holds, and ready stays high while the output register is empty or
// being read.

module datetime_difference
    import dtd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dtd_stamp_if.sink   stamps,
    dtd_span_if.source  span
);

    localparam int KEY_W = DAYS_W + HOUR_W + MINUTE_W + SECOND_W;

    logic       en;
    logic       v_a_reg;
    logic       v_b_reg;
    logic       v_c_reg;
    logic       v_d_reg;
    dtd_stamp_t stamp_first;
    dtd_stamp_t stamp_second;
    dtd_days_t  days_first;
    dtd_days_t  days_second;

    // Stage C registers: ordered pair.
    dtd_days_t  big_reg;
    dtd_days_t  small_reg;
    logic       invalid_reg;

    logic [KEY_W-1:0] key_first;
    logic [KEY_W-1:0] key_second;
    logic             first_ge;

    // Stage D (output) signals.
    dtd_span_t        span_reg;
    dtd_span_t        span_next;
    logic [SECOND_W:0] sec_diff;
    logic [MINUTE_W:0] min_diff;
    logic [HOUR_W:0]   hour_diff;
    logic              borrow_s;
    logic              borrow_m;
    logic              borrow_h;

    // The pipeline moves whenever the output register is free or being read.
    assign en           = !v_d_reg || span.ready;
    assign stamps.ready = en;
    assign span.valid   = v_d_reg;
    assign span.data    = span_reg;

    // Split the input word into its two date-times.
    always_comb
    begin
        stamp_first.day     = stamps.data.first_day;
        stamp_first.month   = stamps.data.first_month;
        stamp_first.year    = stamps.data.first_year;
        stamp_first.hour    = stamps.data.first_hour;
        stamp_first.minute  = stamps.data.first_minute;
        stamp_first.second  = stamps.data.first_second;
        stamp_second.day    = stamps.data.second_day;
        stamp_second.month  = stamps.data.second_month;
        stamp_second.year   = stamps.data.second_year;
        stamp_second.hour   = stamps.data.second_hour;
        stamp_second.minute = stamps.data.second_minute;
        stamp_second.second = stamps.data.second_second;
    end

    dtd_to_days u_conv_first
    (
        .clk    (clk),
        .en     (en),
        .stamp  (stamp_first),
        .result (days_first)
    );

    dtd_to_days u_conv_second
    (
        .clk    (clk),
        .en     (en),
        .stamp  (stamp_second),
        .result (days_second)
    );

    // Valid bits travel alongside the data through all four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end
        else if (en)
        begin
            v_a_reg <= stamps.valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
        end
    end

    // Order the two moments; fields are in range, so the packed key compares
    // lexicographically by day, hour, minute and second.
    always_comb
    begin
        key_first  = {days_first.days, days_first.hour, days_first.minute,
                      days_first.second};
        key_second = {days_second.days, days_second.hour, days_second.minute,
                      days_second.second};
        first_ge   = key_first >= key_second;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg     <= first_ge ? days_first : days_second;
            small_reg   <= first_ge ? days_second : days_first;
            invalid_reg <= !(days_first.ok && days_second.ok);
        end
    end

    // Mixed-radix subtraction with borrows from seconds up to days.
    always_comb
    begin
        sec_diff  = {1'b0, big_reg.second} - {1'b0, small_reg.second};
        borrow_s  = sec_diff[SECOND_W];
        min_diff  = {1'b0, big_reg.minute} - {1'b0, small_reg.minute}
                  - (MINUTE_W+1)'(borrow_s);
        borrow_m  = min_diff[MINUTE_W];
        hour_diff = {1'b0, big_reg.hour} - {1'b0, small_reg.hour}
                  - (HOUR_W+1)'(borrow_m);
        borrow_h  = hour_diff[HOUR_W];

        span_next.invalid     = invalid_reg;
        span_next.second_span = borrow_s ? sec_diff[SECOND_W-1:0] + SECOND_W'(60)
                                         : sec_diff[SECOND_W-1:0];
        span_next.minute_span = borrow_m ? min_diff[MINUTE_W-1:0] + MINUTE_W'(60)
                                         : min_diff[MINUTE_W-1:0];
        span_next.hour_span   = borrow_h ? hour_diff[HOUR_W-1:0] + HOUR_W'(24)
                                         : hour_diff[HOUR_W-1:0];
        span_next.day_span    = big_reg.days - small_reg.days - DAYS_W'(borrow_h);

        // An invalid pair reports zero spans.
        if (invalid_reg)
        begin
            span_next.second_span = '0;
            span_next.minute_span = '0;
            span_next.hour_span   = '0;
            span_next.day_span    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span_reg <= span_next;
        end
    end

endmodule

[test/testbench.sv]
// Self-checking testbench for datetime_difference: directed and random date-time pairs.
// Depends on dtd_pkg, dtd_stamp_if, dtd_span_if and the datetime_difference RTL.
`timescale 1ns / 100ps

module testbench;
    import dtd_pkg::*;

    localparam int    RANDOM_WORDS    = 480;
    localparam int    CALM_WORDS      = 60;
    localparam int    DRAIN_LIMIT     = 2000;
    localparam int    SETTLE_CYCLES   = 10;
    localparam int    MAX_PRINTS      = 40;
    localparam int    PAIR_W          = $bits(dtd_pair_t);
    localparam longint SECONDS_PER_DAY = 86400;

    // One row of the directed table: a word and, where known by hand, its result.
    typedef struct packed {
        dtd_pair_t word;
        logic      typed;
        dtd_span_t golden;
    } stim_row_t;

    logic clk;
    logic rst_n;
    bit   idle_on;

    dtd_span_t spans_due[$];
    int        mismatch_count;
    int        words_sent;
    int        results_checked;
    int        invalid_seen;

    dtd_stamp_if stamps_bus ();
    dtd_span_if  span_bus ();

    datetime_difference u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stamps (stamps_bus),
        .span   (span_bus)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #400000;
        $display("Timed out with %0d results still outstanding.", spans_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Print one error line (up to a cap) and count it.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    // Calendar helpers for the predictor.
    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        int n;
        case (m)
            MONTH_FEB:       n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:     n = 30;
            default:         n = 31;
        endcase
        return n;
    endfunction

    function automatic bit stamp_ok(input dtd_stamp_t t);
        if (t.month < MONTH_JAN || t.month > MONTH_DEC)
            return 1'b0;
        if (t.year > YEAR_MAX || t.hour > HOUR_MAX || t.minute > MINUTE_MAX
            || t.second > SECOND_MAX)
            return 1'b0;
        return (t.day >= 1) && (t.day <= days_in_month(int'(t.month), int'(t.year)));
    endfunction

    // Seconds since the first of January of year 0, leap days counted year by rule.
    function automatic longint stamp_seconds(input dtd_stamp_t t);
        longint days;
        int     y;
        y    = int'(t.year);
        days = longint'(y) * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int k = 1; k < t.month; k++)
            days += days_in_month(k, y);
        days += t.day - 1;
        return days * SECONDS_PER_DAY + t.hour * 3600 + t.minute * 60 + t.second;
    endfunction

    function automatic dtd_stamp_t first_of(input dtd_pair_t w);
        dtd_stamp_t t;
        t.day    = w.first_day;
        t.month  = w.first_month;
        t.year   = w.first_year;
        t.hour   = w.first_hour;
        t.minute = w.first_minute;
        t.second = w.first_second;
        return t;
    endfunction

    function automatic dtd_stamp_t second_of(input dtd_pair_t w);
        dtd_stamp_t t;
        t.day    = w.second_day;
        t.month  = w.second_month;
        t.year   = w.second_year;
        t.hour   = w.second_hour;
        t.minute = w.second_minute;
        t.second = w.second_second;
        return t;
    endfunction

    // Expected span of a word: absolute difference, or the invalid flag alone.
    function automatic dtd_span_t span_between(input dtd_pair_t w);
        dtd_span_t r;
        longint    a;
        longint    b;
        longint    gap;
        longint    rest;
        r = '0;
        if (!stamp_ok(first_of(w)) || !stamp_ok(second_of(w)))
        begin
            r.invalid = 1'b1;
            return r;
        end
        a    = stamp_seconds(first_of(w));
        b    = stamp_seconds(second_of(w));
        gap  = (a > b) ? a - b : b - a;
        rest = gap % SECONDS_PER_DAY;
        r.day_span    = DAYS_W'(gap / SECONDS_PER_DAY);
        r.hour_span   = HOUR_W'(rest / 3600);
        r.minute_span = MINUTE_W'((rest / 60) % 60);
        r.second_span = SECOND_W'(rest % 60);
        return r;
    endfunction

    // Word builders.
    function automatic dtd_stamp_t stamp_of(input int d, input int m, input int y,
                                            input int h, input int mi, input int s);
        dtd_stamp_t t;
        t.day    = DAY_W'(d);
        t.month  = MONTH_W'(m);
        t.year   = YEAR_W'(y);
        t.hour   = HOUR_W'(h);
        t.minute = MINUTE_W'(mi);
        t.second = SECOND_W'(s);
        return t;
    endfunction

    function automatic dtd_pair_t pair_of(input dtd_stamp_t a, input dtd_stamp_t b);
        dtd_pair_t w;
        w.first_day     = a.day;
        w.first_month   = a.month;
        w.first_year    = a.year;
        w.first_hour    = a.hour;
        w.first_minute  = a.minute;
        w.first_second  = a.second;
        w.second_day    = b.day;
        w.second_month  = b.month;
        w.second_year   = b.year;
        w.second_hour   = b.hour;
        w.second_minute = b.minute;
        w.second_second = b.second;
        return w;
    endfunction

    function automatic dtd_span_t span_of(input int inv, input int days, input int h,
                                          input int mi, input int s);
        dtd_span_t r;
        r.invalid     = (inv != 0);
        r.day_span    = DAYS_W'(days);
        r.hour_span   = HOUR_W'(h);
        r.minute_span = MINUTE_W'(mi);
        r.second_span = SECOND_W'(s);
        return r;
    endfunction

    // A well-formed date-time, leaning toward calendar corners.
    function automatic dtd_stamp_t random_stamp();
        int m;
        int y;
        int len;
        int d;
        int h;
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
            0:       y = 0;
            1:       y = 9999;
            2:       y = 400 * $urandom_range(0, 24);
            3:       y = 100 * $urandom_range(0, 99);
            default: y = $urandom_range(0, 9999);
        endcase
        len = days_in_month(m, y);
        d   = ($urandom_range(0, 5) == 0) ? len : $urandom_range(1, len);
        h   = ($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23);
        return stamp_of(d, m, y, h, $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // Spoil exactly one field of a well-formed date-time.
    function automatic dtd_stamp_t break_stamp(input dtd_stamp_t t);
        int len;
        len = days_in_month(int'(t.month), int'(t.year));
        case ($urandom_range(0, 6))
            0: t.day = '0;
            1:
            begin
                if (len == 31)
                    t.month = '0;
                else
                    t.day = DAY_W'($urandom_range(len + 1, 31));
            end
            2: t.month = $urandom_range(0, 1) ? MONTH_W'(0)
                                              : MONTH_W'($urandom_range(13, 15));
            3: t.year = YEAR_W'($urandom_range(10000, 16383));
            4: t.hour = HOUR_W'($urandom_range(24, 31));
            5: t.minute = MINUTE_W'($urandom_range(60, 63));
            default: t.second = SECOND_W'($urandom_range(60, 63));
        endcase
        return t;
    endfunction

    // Mostly well-formed pairs, some close together, some spoiled, some pure noise.
    function automatic dtd_pair_t random_word();
        dtd_stamp_t a;
        dtd_stamp_t b;
        dtd_pair_t  w;
        int         kind;
        kind = $urandom_range(0, 15);
        a    = random_stamp();
        b    = random_stamp();
        if (kind >= 14)
        begin
            w = PAIR_W'({$urandom, $urandom, $urandom});
            return w;
        end
        if (kind >= 12)
        begin
            if ($urandom_range(0, 1))
                a = break_stamp(a);
            else
                b = break_stamp(b);
        end
        else if (kind >= 10)
        begin
            b = a;
            if ($urandom_range(0, 2) != 0)
            begin
                b.hour   = HOUR_W'($urandom_range(0, 23));
                b.minute = MINUTE_W'($urandom_range(0, 59));
                b.second = SECOND_W'($urandom_range(0, 59));
            end
        end
        return pair_of(a, b);
    endfunction

    // Offer one word, with an occasional idle burst first, and wait for acceptance.
    task automatic send_word(input dtd_pair_t w, input dtd_span_t want);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stamps_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        stamps_bus.valid <= 1'b1;
        stamps_bus.data  <= w;
        @(posedge clk);
        while (!stamps_bus.ready)
            @(posedge clk);
        spans_due.push_back(want);
        words_sent++;
    endtask

    // Result side: hold ready low in random bursts while idling is enabled.
    initial
    begin : span_ready_drive
        int hold;
        hold = 0;
        span_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        span_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    span_bus.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 12);
                span_bus.ready <= 1'b0;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : span_check
        dtd_span_t want;
        dtd_span_t got;
        if (rst_n === 1'b1 && span_bus.valid === 1'b1 && span_bus.ready === 1'b1)
        begin
            got = span_bus.data;
            if (spans_due.size() == 0)
                report_mismatch("result word arrived with nothing outstanding");
            else
            begin
                want = spans_due.pop_front();
                results_checked++;
                if (got.invalid === 1'b1)
                    invalid_seen++;
                if (got.invalid !== want.invalid)
                    report_mismatch($sformatf("invalid: got %b, expected %b",
                                              got.invalid, want.invalid));
                if (got.day_span !== want.day_span)
                    report_mismatch($sformatf("day_span: got %0d, expected %0d",
                                              got.day_span, want.day_span));
                if (got.hour_span !== want.hour_span)
                    report_mismatch($sformatf("hour_span: got %0d, expected %0d",
                                              got.hour_span, want.hour_span));
                if (got.minute_span !== want.minute_span)
                    report_mismatch($sformatf("minute_span: got %0d, expected %0d",
                                              got.minute_span, want.minute_span));
                if (got.second_span !== want.second_span)
                    report_mismatch($sformatf("second_span: got %0d, expected %0d",
                                              got.second_span, want.second_span));
            end
        end
    end

    // Main sequence: reset, directed table, random words, drain and verdict.
    initial
    begin : main_flow
        stim_row_t stim_rows[$];
        dtd_span_t no_golden;
        dtd_span_t want;
        int        waited;

        rst_n            <= 1'b0;
        stamps_bus.valid <= 1'b0;
        stamps_bus.data  <= '0;
        idle_on          = 1'b1;
        mismatch_count   = 0;
        words_sent       = 0;
        results_checked  = 0;
        invalid_seen     = 0;
        no_golden        = '0;

        stim_rows = '{
            // All fields zero: day zero and month zero.
            {pair_of(stamp_of(0, 0, 0, 0, 0, 0), stamp_of(0, 0, 0, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            // Earliest date-time against itself.
            {pair_of(stamp_of(1, 1, 0, 0, 0, 0), stamp_of(1, 1, 0, 0, 0, 0)),
             1'b1, span_of(0, 0, 0, 0, 0)},
            // Widest span, both orders.
            {pair_of(stamp_of(1, 1, 0, 0, 0, 0), stamp_of(31, 12, 9999, 23, 59, 59)),
             1'b1, span_of(0, 3652424, 23, 59, 59)},
            {pair_of(stamp_of(31, 12, 9999, 23, 59, 59), stamp_of(1, 1, 0, 0, 0, 0)),
             1'b1, span_of(0, 3652424, 23, 59, 59)},
            // Every field at its all-ones value.
            {pair_of(stamp_of(31, 15, 16383, 31, 63, 63), stamp_of(31, 15, 16383, 31, 63, 63)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            // Single bad field on one side.
            {pair_of(stamp_of(0, 6, 2000, 12, 0, 0), stamp_of(1, 6, 2000, 12, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(1, 6, 2000, 12, 0, 0), stamp_of(1, 13, 2000, 12, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(5, 0, 2000, 12, 0, 0), stamp_of(1, 6, 2000, 12, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(1, 1, 10000, 0, 0, 0), stamp_of(1, 1, 9999, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(1, 1, 2020, 24, 0, 0), stamp_of(1, 1, 2020, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(1, 1, 2020, 0, 0, 0), stamp_of(1, 1, 2020, 0, 60, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(1, 1, 2020, 0, 0, 60), stamp_of(1, 1, 2020, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            // Month lengths: February 29 of a century year, February 30, April 31.
            {pair_of(stamp_of(29, 2, 1900, 0, 0, 0), stamp_of(1, 3, 1900, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(30, 2, 2000, 0, 0, 0), stamp_of(1, 3, 2000, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            {pair_of(stamp_of(31, 4, 2021, 0, 0, 0), stamp_of(1, 5, 2021, 0, 0, 0)),
             1'b1, span_of(1, 0, 0, 0, 0)},
            // Leap day crossings in a 400-year, a plain century and year zero.
            {pair_of(stamp_of(29, 2, 2000, 8, 0, 0), stamp_of(1, 3, 2000, 8, 0, 0)),
             1'b1, span_of(0, 1, 0, 0, 0)},
            {pair_of(stamp_of(28, 2, 1900, 8, 0, 0), stamp_of(1, 3, 1900, 8, 0, 0)),
             1'b1, span_of(0, 1, 0, 0, 0)},
            {pair_of(stamp_of(29, 2, 0, 0, 0, 0), stamp_of(1, 3, 0, 0, 0, 0)),
             1'b1, span_of(0, 1, 0, 0, 0)},
            // One second across a year boundary.
            {pair_of(stamp_of(31, 12, 1999, 23, 59, 59), stamp_of(1, 1, 2000, 0, 0, 0)),
             1'b1, span_of(0, 0, 0, 0, 1)},
            // Equal date-times away from zero.
            {pair_of(stamp_of(29, 2, 2024, 13, 37, 42), stamp_of(29, 2, 2024, 13, 37, 42)),
             1'b1, span_of(0, 0, 0, 0, 0)},
            // A whole leap year, and a span across the end of April.
            {pair_of(stamp_of(1, 1, 2000, 0, 0, 0), stamp_of(1, 1, 2001, 0, 0, 0)),
             1'b1, span_of(0, 366, 0, 0, 0)},
            {pair_of(stamp_of(30, 4, 2021, 0, 0, 0), stamp_of(1, 5, 2021, 23, 59, 59)),
             1'b1, span_of(0, 1, 23, 59, 59)},
            // Ordinary pairs left to the predictor.
            {pair_of(stamp_of(15, 6, 1987, 12, 34, 56), stamp_of(3, 11, 2023, 7, 8, 9)),
             1'b0, no_golden},
            {pair_of(stamp_of(31, 12, 9999, 0, 0, 0), stamp_of(1, 12, 9999, 23, 59, 59)),
             1'b0, no_golden},
            {pair_of(stamp_of(31, 1, 9999, 23, 59, 59), stamp_of(28, 2, 4, 22, 1, 2)),
             1'b0, no_golden}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words.
        foreach (stim_rows[i])
        begin
            want = stim_rows[i].typed ? stim_rows[i].golden : span_between(stim_rows[i].word);
            send_word(stim_rows[i].word, want);
        end

        // Random words; the last stretch runs with no idling on either side.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            dtd_pair_t w;
            if (n == RANDOM_WORDS - CALM_WORDS)
                idle_on = 1'b0;
            w = random_word();
            send_word(w, span_between(w));
        end
        stamps_bus.valid <= 1'b0;

        // Let the pipeline drain, then keep watching for stray results.
        waited = 0;
        while (spans_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (spans_due.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      spans_due.size()));

        $display("Covered %0d words (%0d directed), %0d results checked, %0d invalid.",
                 words_sent, stim_rows.size(), results_checked, invalid_seen);
        $display("Mismatches counted: %0d.", mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
